// File: src/assert_macros.svh
// Assertion helpers used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored during reset
`define RBC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");

// next-cycle implication, ignored during reset
`define RBC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// File: src/rbc_pkg.sv
package rbc_pkg;

  // divider sizes: dividend is |edge - origin| * 2^15
  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 16;
  localparam int COUNT_W    = 6;
  // slab parameter width, with room for the infinity marks
  localparam int T_W        = 52;
  localparam logic signed [T_W-1:0] T_INF = 52'sd1 <<< 50;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

  // hit kinds
  localparam logic [1:0] KIND_NONE = 2'd0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LAUNCH,
    ST_WAIT,
    ST_SLAB,
    ST_MERGE,
    ST_PX_MUL,
    ST_PX_ADD,
    ST_PY_MUL,
    ST_PY_ADD,
    ST_FINISH
  } state_t;

endpackage

// File: src/rbc_serial_div.sv
module rbc_serial_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rbc_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [rbc_pkg::DIVISOR_W-1:0]    divisor,
  output logic [rbc_pkg::DIVIDEND_W-1:0]   quotient,
  output rbc_pkg::div_status_t             status
);
  import rbc_pkg::*;

  logic [DIVIDEND_W-1:0] shreg;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W-1:0]  rem;
  logic [COUNT_W-1:0]    cnt;
  logic                  busy;
  logic                  done;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  qbit;

  // one restoring step: bring down the next dividend bit
  assign rem_sh = {rem, shreg[DIVIDEND_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs});

  // dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= COUNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == COUNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[DIVIDEND_W-2:0], qbit};
      rem   <= qbit ? DIVISOR_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign quotient    = shreg;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: src/ray_box_closest_hit_top.sv
// From item accept to out_valid: four serial divisions on the shared
//   bit-serial divider (setup, launch, 49 quotient bits, handoff), then slab
//   test, merge and two end point multiply-adds. One item at a time: a new
//   item is accepted only in idle, after that sequence; a ray's last item
//   also waits in finish while the previous result is unread.
// Reset (rst, synchronous, active high): configuration, op, running hit and out_valid go to zero.
module ray_box_closest_hit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first_of_ray,
  input  logic        last_of_ray,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [31:0] box_left,
  input  logic signed [31:0] box_top,
  input  logic [30:0] box_width,
  input  logic [30:0] box_height,
  input  logic        box_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  hit_kind,
  output logic [30:0] hit_distance,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y
);
  import rbc_pkg::*;
  `include "assert_macros.svh"

  state_t state, state_next;

  // configuration
  logic signed [31:0] origin_x, origin_y;
  logic [30:0]        max_length;

  // latched item
  logic               last_q, kind_q;
  logic signed [15:0] dx, dy;
  logic signed [31:0] left, top;
  logic [30:0]        width, height;

  // running nearest hit
  logic [30:0]        best_distance;
  logic [1:0]         best_kind;
  logic signed [31:0] best_x, best_y;

  // division sequencing
  logic [1:0]              op;
  logic                    neg;
  logic [DIVIDEND_W-1:0]   dividend;
  logic [DIVISOR_W-1:0]    divisor;
  logic [DIVIDEND_W-1:0]   quotient;
  div_status_t             div_status;
  logic                    div_start;
  logic signed [T_W-1:0]   tq [4];

  // slab results
  logic                    okx, oky, upd;
  logic signed [T_W-1:0]   txl, txh, tyl, tyh;
  logic signed [47:0]      prod;
  logic signed [31:0]      px, py;

  // setup arithmetic for the current edge
  logic signed [34:0] edge_v, org_v, diff;
  logic signed [15:0] dir_c;
  logic [33:0]        diff_mag;

  // slab arithmetic
  logic signed [34:0] xhi, yhi;
  logic               inx, iny, hit, better;
  logic signed [T_W-1:0] tin;
  logic signed [15:0] dir_m;

  rbc_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .status   (div_status)
  );

  // configuration port: always ready, unknown index ignored
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      max_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X:   origin_x   <= cfg_data;
        CFG_ORIGIN_Y:   origin_y   <= cfg_data;
        CFG_MAX_LENGTH: max_length <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_WAIT;
      ST_WAIT:   if (div_status.done) state_next = (op == 2'd3) ? ST_SLAB : ST_SETUP;
      ST_SLAB:   state_next = ST_MERGE;
      ST_MERGE:  state_next = ST_PX_MUL;
      ST_PX_MUL: state_next = ST_PX_ADD;
      ST_PX_ADD: state_next = ST_PY_MUL;
      ST_PY_MUL: state_next = ST_PY_ADD;
      ST_PY_ADD: state_next = ST_FINISH;
      ST_FINISH: if (!last_q || !out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_LAUNCH: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // edge minus origin for op: bit 1 picks the axis, bit 0 the far edge
  always_comb begin
    if (op[1]) begin
      edge_v = 35'(top) + (op[0] ? 35'(signed'({1'b0, height})) : 35'sd0);
      org_v  = 35'(origin_y);
      dir_c  = dy;
    end else begin
      edge_v = 35'(left) + (op[0] ? 35'(signed'({1'b0, width})) : 35'sd0);
      org_v  = 35'(origin_x);
      dir_c  = dx;
    end
    diff     = edge_v - org_v;
    diff_mag = diff[34] ? 34'(-diff) : diff[33:0];
  end

  // slab bounds per axis, zero direction handled by containment
  always_comb begin
    xhi = 35'(left) + 35'(signed'({1'b0, width}));
    yhi = 35'(top) + 35'(signed'({1'b0, height}));
    inx = (35'(origin_x) >= 35'(left)) && (35'(origin_x) <= xhi);
    iny = (35'(origin_y) >= 35'(top)) && (35'(origin_y) <= yhi);
    hit = okx && oky && !(txl > tyh || tyl > txh);
    tin = (txl > tyl) ? txl : tyl;
    // in front of the origin and strictly nearer than the running best
    better = hit && (tin >= 0) && (tin < T_W'(signed'({1'b0, best_distance})));
    dir_m = (state == ST_PY_MUL) ? dy : dx;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      op            <= '0;
      best_distance <= '0;
      best_kind     <= KIND_NONE;
      best_x        <= '0;
      best_y        <= '0;
      out_valid     <= 1'b0;
    end else begin
      // output register: loaded by a ray's last item, cleared on handoff
      if (state == ST_FINISH && last_q && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready)                               out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last_q <= last_of_ray;
            kind_q <= box_kind;
            dx     <= dir_x;
            dy     <= dir_y;
            left   <= box_left;
            top    <= box_top;
            width  <= box_width;
            height <= box_height;
            op     <= '0;
            if (first_of_ray) begin
              best_distance <= max_length;
              best_kind     <= KIND_NONE;
              best_x        <= '0;
              best_y        <= '0;
            end
          end
        end
        ST_SETUP: begin
          dividend <= {diff_mag, 15'd0};
          divisor  <= dir_c[15] ? 16'(-dir_c) : dir_c;
          neg      <= diff[34] ^ dir_c[15];
        end
        ST_WAIT: begin
          if (div_status.done) begin
            tq[op] <= neg ? -T_W'(quotient) : T_W'(quotient);
            op     <= op + 1'b1;
          end
        end
        ST_SLAB: begin
          if (dx == 16'sd0) begin
            okx <= inx;
            txl <= -T_INF;
            txh <= T_INF;
          end else begin
            okx <= 1'b1;
            txl <= (tq[0] > tq[1]) ? tq[1] : tq[0];
            txh <= (tq[0] > tq[1]) ? tq[0] : tq[1];
          end
          if (dy == 16'sd0) begin
            oky <= iny;
            tyl <= -T_INF;
            tyh <= T_INF;
          end else begin
            oky <= 1'b1;
            tyl <= (tq[2] > tq[3]) ? tq[3] : tq[2];
            tyh <= (tq[2] > tq[3]) ? tq[2] : tq[3];
          end
        end
        ST_MERGE: begin
          upd <= better;
          if (better) begin
            best_distance <= tin[30:0];
            best_kind     <= {kind_q, ~kind_q};
          end
        end
        ST_PX_MUL, ST_PY_MUL: begin
          prod <= 48'(dir_m * signed'({1'b0, best_distance}));
        end
        ST_PX_ADD: begin
          px <= origin_x + prod[46:15];
          if (upd) best_x <= origin_x + prod[46:15];
        end
        ST_PY_ADD: begin
          py <= origin_y + prod[46:15];
          if (upd) best_y <= origin_y + prod[46:15];
        end
        ST_FINISH: begin
          if (last_q && (!out_valid || out_ready)) begin
            hit_kind     <= best_kind;
            hit_distance <= best_distance;
            hit_x        <= (best_kind == KIND_NONE) ? px : best_x;
            hit_y        <= (best_kind == KIND_NONE) ? py : best_y;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  `RBC_ASSERT_IMP(a_div_idle, state == ST_IDLE, !div_status.busy)
  `RBC_ASSERT_NEXT(a_accept_setup, in_valid && in_ready, state == ST_SETUP)
  `RBC_ASSERT_IMP(a_out_from_finish, $rose(out_valid), $past(state) == ST_FINISH)

endmodule
